>>> rtl/core/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SLBT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("slbt assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SLBT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("slbt assertion failed");

`endif

>>> rtl/core/slbt_pkg.sv
// shared constants, types and the arctangent table of the bearing tracker
package slbt_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int COORD_WIDTH   = 16;
  localparam int MAX_STAGES    = 24;

  localparam int FIELD_W = 16;
  localparam int DIFF_W  = 17;
  localparam int STEP_W  = 10;
  localparam int ROT_W   = 17;
  localparam int ZW      = 25;
  localparam int TAB_W   = 21;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd2;

  localparam logic signed [FIELD_W-1:0] CENTER_X_RST  = 16'sd400;
  localparam logic signed [FIELD_W-1:0] CENTER_Y_RST  = 16'sd300;
  localparam logic        [STEP_W-1:0]  STEP_SIZE_RST = 10'd15;

  localparam int HALF_TURN = 18000;
  localparam int FULL_TURN = 36000;
  localparam logic signed [ZW-1:0] Z_HALF_TURN = 25'sd4608000;

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

  function automatic logic [TAB_W-1:0] atan_tab(input int idx);
    logic [TAB_W-1:0] v;
    unique case (idx)
      0:  v = 21'd1152000;
      1:  v = 21'd680065;
      2:  v = 21'd359328;
      3:  v = 21'd182400;
      4:  v = 21'd91554;
      5:  v = 21'd45822;
      6:  v = 21'd22916;
      7:  v = 21'd11459;
      8:  v = 21'd5730;
      9:  v = 21'd2865;
      10: v = 21'd1432;
      11: v = 21'd716;
      12: v = 21'd358;
      13: v = 21'd179;
      14: v = 21'd90;
      15: v = 21'd45;
      16: v = 21'd22;
      17: v = 21'd11;
      18: v = 21'd6;
      19: v = 21'd3;
      20: v = 21'd1;
      21: v = 21'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/slew_limited_bearing_tracker_core.sv
// top level: cordic bearing chain followed by the slew limiter
// an accepted beat passes the input, cordic cell, rounding and output registers
// throughput: one beat per cycle while the output is not stalled, one cordic cell per stage
// a stalled output beat holds the whole pipeline, so input stall follows output stall
// reset: asynchronous, clears pipeline valids and the tracked angle, loads register defaults
module slew_limited_bearing_tracker_core #(
  parameter int CORDIC_STAGES = slbt_pkg::CORDIC_STAGES,
  parameter int COORD_WIDTH   = slbt_pkg::COORD_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [slbt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [slbt_pkg::FIELD_W-1:0]  cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [slbt_pkg::FIELD_W-1:0]  target_x_i,
  input  logic signed [slbt_pkg::FIELD_W-1:0]  target_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [slbt_pkg::ROT_W-1:0]    rotation_o,
  output logic                                 rotation_set_o
);

  localparam int SHIFT = 40 - COORD_WIDTH;
  localparam int DW    = SHIFT + 20;
  localparam int DXW   = slbt_pkg::DIFF_W;

  logic signed [slbt_pkg::FIELD_W-1:0] center_x_q, center_y_q;
  logic        [slbt_pkg::STEP_W-1:0]  step_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= slbt_pkg::CENTER_X_RST;
      center_y_q  <= slbt_pkg::CENTER_Y_RST;
      step_size_q <= slbt_pkg::STEP_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        slbt_pkg::REG_CENTER_X:  center_x_q  <= cfg_data_i;
        slbt_pkg::REG_CENTER_Y:  center_y_q  <= cfg_data_i;
        slbt_pkg::REG_STEP_SIZE: step_size_q <= cfg_data_i[slbt_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid;

  assign adv        = !(out_valid && out_stall_i);
  assign in_stall_o = !adv;

  // input stage: offset from the pivot, half-plane fold, prescale
  logic signed [DXW-1:0] dx, dy;
  logic signed [DW-1:0]  dx_w, dy_w, xf, yf;

  assign dx   = DXW'(target_x_i) - DXW'(center_x_q);
  assign dy   = DXW'(target_y_i) - DXW'(center_y_q);
  assign dx_w = DW'(dx);
  assign dy_w = DW'(dy);
  assign xf   = dx[DXW-1] ? -dx_w : dx_w;
  assign yf   = dx[DXW-1] ? -dy_w : dy_w;

  slbt_pkg::ctl_t                 ctl_s [0:CORDIC_STAGES];
  logic signed [DW-1:0]           x_s   [0:CORDIC_STAGES];
  logic signed [DW-1:0]           y_s   [0:CORDIC_STAGES];
  logic signed [slbt_pkg::ZW-1:0] z_s   [0:CORDIC_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s[0] <= '0;
    end else if (adv) begin
      ctl_s[0].valid <= in_valid_i;
      ctl_s[0].zero  <= (dx == '0) && (dy == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_s[0] <= xf <<< SHIFT;
      y_s[0] <= yf <<< SHIFT;
      z_s[0] <= dx[DXW-1] ? slbt_pkg::Z_HALF_TURN : '0;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    slbt_cordic_cell #(
      .DW    (DW),
      .STAGE (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctl_i  (ctl_s[g]),
      .x_i    (x_s[g]),
      .y_i    (y_s[g]),
      .z_i    (z_s[g]),
      .ctl_o  (ctl_s[g+1]),
      .x_o    (x_s[g+1]),
      .y_o    (y_s[g+1]),
      .z_o    (z_s[g+1])
    );
  end

  slbt_limiter u_limiter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .ctl_i          (ctl_s[CORDIC_STAGES]),
    .z_i            (z_s[CORDIC_STAGES]),
    .step_size_i    (step_size_q),
    .out_valid_o    (out_valid),
    .rotation_o     (rotation_o),
    .rotation_set_o (rotation_set_o)
  );

  assign out_valid_o = out_valid;

endmodule

>>> rtl/core/slbt_cordic_cell.sv
// one vectoring stage of the cordic chain
module slbt_cordic_cell #(
  parameter int DW    = 44,
  parameter int STAGE = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  slbt_pkg::ctl_t                   ctl_i,
  input  logic signed [DW-1:0]             x_i,
  input  logic signed [DW-1:0]             y_i,
  input  logic signed [slbt_pkg::ZW-1:0]   z_i,
  output slbt_pkg::ctl_t                   ctl_o,
  output logic signed [DW-1:0]             x_o,
  output logic signed [DW-1:0]             y_o,
  output logic signed [slbt_pkg::ZW-1:0]   z_o
);

  localparam logic signed [slbt_pkg::ZW-1:0] ATAN =
    signed'(slbt_pkg::ZW'(slbt_pkg::atan_tab(STAGE)));

  slbt_pkg::ctl_t                 ctl_q;
  logic signed [DW-1:0]           x_q, x_d, y_q, y_d;
  logic signed [slbt_pkg::ZW-1:0] z_q, z_d;
  logic signed [DW-1:0]           xs, ys;

  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  always_comb begin
    if (y_i > 0) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

>>> rtl/core/slbt_limiter.sv
// bearing rounding stage and slew limiter with the tracked angle
module slbt_limiter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  slbt_pkg::ctl_t                      ctl_i,
  input  logic signed [slbt_pkg::ZW-1:0]      z_i,
  input  logic        [slbt_pkg::STEP_W-1:0]  step_size_i,
  output logic                                out_valid_o,
  output logic signed [slbt_pkg::ROT_W-1:0]   rotation_o,
  output logic                                rotation_set_o
);

  localparam int HW = slbt_pkg::ZW - 8;
  localparam int LW = 19;
  localparam logic signed [HW-1:0] H_FULL = HW'(slbt_pkg::FULL_TURN);
  localparam logic signed [LW-1:0] L_FULL = LW'(slbt_pkg::FULL_TURN);
  localparam logic signed [LW-1:0] L_HALF = LW'(slbt_pkg::HALF_TURN);

  // rounding stage
  logic                           fin_valid_q;
  logic signed [slbt_pkg::ROT_W-1:0] bearing_q, bearing_d;
  logic signed [slbt_pkg::ZW-1:0] z_rnd;
  logic signed [HW-1:0]           h_raw, h_wrap;

  assign z_rnd = z_i + slbt_pkg::ZW'(128);
  assign h_raw = HW'(z_rnd >>> 8);

  always_comb begin
    if (h_raw < 0) begin
      h_wrap = h_raw + H_FULL;
    end else if (h_raw >= H_FULL) begin
      h_wrap = h_raw - H_FULL;
    end else begin
      h_wrap = h_raw;
    end
    bearing_d = ctl_i.zero ? '0 : slbt_pkg::ROT_W'(h_wrap);
  end

  // limiter stage
  logic                              has_q;
  logic signed [slbt_pkg::ROT_W-1:0] tracked_q, tracked_d;
  logic                              out_valid_q;
  logic signed [slbt_pkg::ROT_W-1:0] rot_q, rot_d;
  logic                              set_q, set_d;
  logic signed [LW-1:0]              a_w, t_w, t_fix, s_w, d_w, t_new;
  logic                              dn, up, snap;

  always_comb begin
    a_w   = LW'(bearing_q);
    t_w   = LW'(tracked_q);
    s_w   = signed'(LW'(step_size_i));
    d_w   = a_w - t_w;
    if (t_w < 0) begin
      t_fix = L_FULL;
    end else if (t_w > L_FULL) begin
      t_fix = '0;
    end else begin
      t_fix = t_w;
    end
    dn    = (d_w <= -s_w || d_w > L_HALF) && d_w > -L_HALF;
    up    = (d_w >= s_w || d_w < -L_HALF) && d_w < L_HALF;
    snap  = (d_w > 0 && d_w <= s_w) || (d_w < 0 && d_w >= -s_w);
    if (dn) begin
      t_new = t_fix - s_w;
    end else if (up) begin
      t_new = t_fix + s_w;
    end else begin
      t_new = a_w;
    end
    if (!has_q) begin
      tracked_d = bearing_q;
      set_d     = 1'b0;
      rot_d     = '0;
    end else begin
      tracked_d = slbt_pkg::ROT_W'(t_new);
      set_d     = dn | up | snap;
      rot_d     = set_d ? slbt_pkg::ROT_W'(t_new) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      has_q       <= 1'b0;
      tracked_q   <= '0;
    end else if (adv_i) begin
      fin_valid_q <= ctl_i.valid;
      out_valid_q <= fin_valid_q;
      if (fin_valid_q) begin
        has_q     <= 1'b1;
        tracked_q <= tracked_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bearing_q <= bearing_d;
      if (fin_valid_q) begin
        rot_q <= rot_d;
        set_q <= set_d;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rotation_o     = rot_q;
  assign rotation_set_o = set_q;

endmodule

>>> rtl/core/slbt_checker.sv
// port-level checker for the bearing tracker and its bind
`include "assert_macros.svh"

module slbt_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [slbt_pkg::ROT_W-1:0]    rotation_o,
  input logic                                 rotation_set_o
);

  // a full step either way from a wrapped angle
  localparam logic signed [slbt_pkg::ROT_W-1:0] ROT_LO =
    slbt_pkg::ROT_W'(-(2 ** slbt_pkg::STEP_W - 1));
  localparam logic signed [slbt_pkg::ROT_W-1:0] ROT_HI =
    slbt_pkg::ROT_W'(slbt_pkg::FULL_TURN + 2 ** slbt_pkg::STEP_W - 1);

  logic rot_in_range;

  assign rot_in_range = (rotation_o >= ROT_LO) && (rotation_o <= ROT_HI);

  `SLBT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `SLBT_ASSERT_NEXT(a_rot_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(rotation_o))
  `SLBT_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `SLBT_ASSERT_IMPL(a_rot_zero, clk_i, rst_ni, out_valid_o && !rotation_set_o, rotation_o == '0)
  `SLBT_ASSERT_IMPL(a_rot_range, clk_i, rst_ni, out_valid_o && rotation_set_o, rot_in_range)

endmodule

bind slew_limited_bearing_tracker_core slbt_checker u_slbt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .rotation_o     (rotation_o),
  .rotation_set_o (rotation_set_o)
);

>>> bench/tb.sv
// self-checking bench for the slew limited bearing tracker core
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = slbt_pkg::CORDIC_STAGES + 8;
  localparam int Q8_SHIFT       = 40 - slbt_pkg::COORD_WIDTH;
  localparam int HALF_CIRCLE    = 18000;
  localparam int FULL_CIRCLE    = 36000;
  localparam int PIVOT_X_DEFAULT = 400;
  localparam int PIVOT_Y_DEFAULT = 300;
  localparam int STEP_DEFAULT    = 15;
  localparam logic [slbt_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [slbt_pkg::ROT_W-1:0] rotation;
    logic                              rotation_set;
  } heading_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_we_i = 1'b0;
  logic        [slbt_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic        [slbt_pkg::FIELD_W-1:0] cfg_data_i = '0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic signed [slbt_pkg::FIELD_W-1:0] target_x_i = '0;
  logic signed [slbt_pkg::FIELD_W-1:0] target_y_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [slbt_pkg::ROT_W-1:0]   rotation_o;
  logic                                rotation_set_o;

  longint atan_q8 [slbt_pkg::MAX_STAGES] = '{
    1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45,
    22, 11, 6, 3, 1, 1, 0, 0
  };

  logic signed [15:0] pivot_x = 16'(PIVOT_X_DEFAULT);
  logic signed [15:0] pivot_y = 16'(PIVOT_Y_DEFAULT);
  logic        [9:0]  slew_step = 10'(STEP_DEFAULT);
  int                 tracked_angle = 0;
  bit                 have_angle = 1'b0;
  logic signed [15:0] last_x = '0;
  logic signed [15:0] last_y = '0;

  heading_t expected_headings[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int n_points = 0;
  int n_checked = 0;
  int n_steps = 0;
  int n_snaps = 0;
  int n_holds = 0;
  int n_reg_writes = 0;

  slew_limited_bearing_tracker_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .target_x_i     (target_x_i),
    .target_y_i     (target_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .rotation_o     (rotation_o),
    .rotation_set_o (rotation_set_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int cordic_bearing(input logic signed [15:0] tx,
                                        input logic signed [15:0] ty);
    longint px, py, pz, sx, sy, h;
    px = longint'(tx) - longint'(pivot_x);
    py = longint'(ty) - longint'(pivot_y);
    pz = 0;
    if (px == 0 && py == 0) return 0;
    px = px <<< Q8_SHIFT;
    py = py <<< Q8_SHIFT;
    if (px < 0) begin
      px = -px;
      py = -py;
      pz = longint'(HALF_CIRCLE) * 256;
    end
    for (int i = 0; i < slbt_pkg::CORDIC_STAGES && i < slbt_pkg::MAX_STAGES; i++) begin
      sx = px >>> i;
      sy = py >>> i;
      if (py > 0) begin
        px += sy;
        py -= sx;
        pz += atan_q8[i];
      end else begin
        px -= sy;
        py += sx;
        pz -= atan_q8[i];
      end
    end
    h = (pz + 128) >>> 8;
    while (h < 0) h += FULL_CIRCLE;
    while (h >= FULL_CIRCLE) h -= FULL_CIRCLE;
    return int'(h);
  endfunction

  function automatic heading_t track_point(input logic signed [15:0] tx,
                                           input logic signed [15:0] ty);
    heading_t res;
    int a, s, d;
    a = cordic_bearing(tx, ty);
    s = int'(slew_step);
    res.rotation = '0;
    res.rotation_set = 1'b0;
    if (!have_angle) begin
      tracked_angle = a;
      have_angle = 1'b1;
      n_holds++;
    end else begin
      d = a - tracked_angle;
      if (tracked_angle < 0) tracked_angle = FULL_CIRCLE;
      else if (tracked_angle > FULL_CIRCLE) tracked_angle = 0;
      if ((d <= -s || d > HALF_CIRCLE) && d > -HALF_CIRCLE) begin
        tracked_angle -= s;
        res.rotation = 17'(tracked_angle);
        res.rotation_set = 1'b1;
        n_steps++;
      end else if ((d >= s || d < -HALF_CIRCLE) && d < HALF_CIRCLE) begin
        tracked_angle += s;
        res.rotation = 17'(tracked_angle);
        res.rotation_set = 1'b1;
        n_steps++;
      end else if ((d > 0 && d <= s) || (d < 0 && d >= -s)) begin
        tracked_angle = a;
        res.rotation = 17'(a);
        res.rotation_set = 1'b1;
        n_snaps++;
      end else begin
        tracked_angle = a;
        n_holds++;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, n_checked, got, want);
  endtask

  // a beat is left on the bus after acceptance; the next call replaces or drops it
  task automatic send_point(input logic signed [15:0] tx, input logic signed [15:0] ty);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    target_x_i <= tx;
    target_y_i <= ty;
    do @(posedge clk_i); while (in_stall_o);
    expected_headings.push_back(track_point(tx, ty));
    last_x = tx;
    last_y = ty;
    n_points++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_headings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [slbt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      slbt_pkg::REG_CENTER_X:  pivot_x = data;
      slbt_pkg::REG_CENTER_Y:  pivot_y = data;
      slbt_pkg::REG_STEP_SIZE: slew_step = data[9:0];
      default: ;
    endcase
    n_reg_writes++;
  endtask

  task automatic random_config();
    int pick;
    logic [9:0] step;
    logic [15:0] cx, cy;
    pick = $urandom_range(3);
    case (pick)
      0: begin
        cx = 16'($urandom);
        cy = 16'($urandom);
      end
      1: begin
        cx = $urandom_range(1) ? 16'h7fff : 16'h8000;
        cy = $urandom_range(1) ? 16'h7fff : 16'h8000;
      end
      2: begin
        cx = 16'(int'($urandom_range(1000)) - 500);
        cy = 16'(int'($urandom_range(1000)) - 500);
      end
      default: begin
        cx = 16'(PIVOT_X_DEFAULT);
        cy = 16'(PIVOT_Y_DEFAULT);
      end
    endcase
    pick = $urandom_range(4);
    case (pick)
      0: step = 10'd1;
      1: step = 10'd1000;
      2: step = 10'd1023;
      3: step = 10'(STEP_DEFAULT);
      default: step = 10'($urandom_range(1023, 1));
    endcase
    write_reg(slbt_pkg::REG_CENTER_X, cx);
    write_reg(slbt_pkg::REG_CENTER_Y, cy);
    write_reg(slbt_pkg::REG_STEP_SIZE, {6'($urandom_range(63)), step});
  endtask

  task automatic send_random_point();
    int r;
    logic signed [15:0] tx, ty;
    r = $urandom_range(99);
    if (r < 25) begin
      tx = 16'($urandom);
      ty = 16'($urandom);
    end else if (r < 60) begin
      tx = 16'(int'(last_x) + int'($urandom_range(8)) - 4);
      ty = 16'(int'(last_y) + int'($urandom_range(8)) - 4);
    end else if (r < 70) begin
      tx = 16'(int'(last_x) + int'($urandom_range(400)) - 200);
      ty = 16'(int'(last_y) + int'($urandom_range(400)) - 200);
    end else if (r < 82) begin
      tx = last_x;
      ty = last_y;
    end else if (r < 92) begin
      tx = 16'(2 * int'(pivot_x) - int'(last_x));
      ty = 16'(2 * int'(pivot_y) - int'(last_y));
    end else begin
      tx = 16'(int'(pivot_x) + int'($urandom_range(4)) - 2);
      ty = 16'(int'(pivot_y) + int'($urandom_range(4)) - 2);
    end
    send_point(tx, ty);
  endtask

  // zero step first, while the first bearing is still to be stored
  task automatic test_zero_step();
    write_reg(slbt_pkg::REG_STEP_SIZE, 16'd0);
    send_point(16'sd500, 16'sd400);
    send_point(16'sd500, 16'sd400);
    send_point(16'sd100, 16'sd300);
    settle();
    write_reg(REG_SPARE, 16'hffff);
    write_reg(slbt_pkg::REG_STEP_SIZE, 16'(STEP_DEFAULT));
  endtask

  task automatic test_hold_and_snap();
    send_point(16'sd300, 16'sd200);
    send_point(16'sd500, 16'sd400);
    send_point(16'sd500, 16'sd400);
    send_point(16'sd10400, 16'sd10320);
    send_point(16'sd400, 16'sd300);
    send_point(16'sd300, 16'sd300);
    settle();
    // large steps around the zero bearing force both wraps
    write_reg(slbt_pkg::REG_STEP_SIZE, 16'd1023);
    repeat (4) begin
      send_point(16'sd1400, 16'sd299);
      send_point(16'sd1400, 16'sd301);
    end
    settle();
  endtask

  task automatic test_field_extremes();
    write_reg(slbt_pkg::REG_CENTER_X, 16'h8000);
    write_reg(slbt_pkg::REG_CENTER_Y, 16'h7fff);
    send_point(16'sh7fff, 16'sh8000);
    send_point(16'sh8000, 16'sh7fff);
    send_point(16'sh7fff, 16'sh7fff);
    settle();
    write_reg(slbt_pkg::REG_CENTER_X, 16'h7fff);
    write_reg(slbt_pkg::REG_CENTER_Y, 16'h8000);
    send_point(16'sh8000, 16'sh7fff);
    send_point(16'sh8000, 16'sh8000);
    settle();
  endtask

  task automatic run_random_phase(input int send_pct, input int stall_pct_v);
    send_idle_pct = send_pct;
    stall_pct = stall_pct_v;
    repeat (3) begin
      settle();
      random_config();
      repeat (100) send_random_point();
    end
    settle();
  endtask

  always @(posedge clk_i) begin : result_check
    heading_t want;
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_headings.size() == 0) begin
        report_mismatch("unexpected beat", int'(rotation_o), 0);
      end else begin
        want = expected_headings.pop_front();
        if (rotation_o !== want.rotation)
          report_mismatch("rotation", int'(rotation_o), int'(want.rotation));
        if (rotation_set_o !== want.rotation_set)
          report_mismatch("rotation_set", int'(rotation_set_o), int'(want.rotation_set));
      end
      n_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_step();
    test_hold_and_snap();
    test_field_extremes();
    run_random_phase(0, 0);
    run_random_phase(56, 0);
    run_random_phase(0, 56);
    run_random_phase(31, 31);
    $display("%0d points sent, %0d results checked (%0d steps, %0d snaps, %0d holds)",
             n_points, n_checked, n_steps, n_snaps, n_holds);
    $display("%0d register writes, idling on neither, sender, receiver and both sides",
             n_reg_writes);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/slbt_pkg.sv
rtl/core/slbt_cordic_cell.sv
rtl/core/slbt_limiter.sv
rtl/core/slew_limited_bearing_tracker_core.sv
rtl/core/slbt_checker.sv
bench/tb.sv
